[design/ttcw_pkg.sv]
// ----------------------------------------------------------------------------
// ttcw_pkg: shared types and constants of the text terminal cell writer
// Field widths, item codes, character codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcw_pkg;

  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int RROW_W    = 5;
  localparam int RCOL_W    = 7;
  localparam int CELL_W    = 16;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int POS_W     = 11;
  localparam int TAB_CNT_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [TAB_CNT_W-1:0] TAB_EXTRA = 2'd3;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_BLANK};

  typedef struct packed {
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [POS_W-1:0]     cursor_position;
  } ttcw_result_t;

endpackage

`default_nettype wire

[design/ttcw_ram.sv]
// ----------------------------------------------------------------------------
// ttcw_ram: generic single-port RAM
// One access per cycle; write when enabled, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/ttcw_engine.sv]
// ----------------------------------------------------------------------------
// ttcw_engine: screen sequencer of the text terminal cell writer
// Holds the cursor and the top-row pointer and drives the screen RAM one
// access per cycle for the reset sweep, puts, backspace, scroll blanking, clear and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcw_engine
  import ttcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [RROW_W-1:0] read_row_i,
  input  wire logic [RCOL_W-1:0] read_col_i,
  input  wire logic              cfg_valid_i,
  input  wire logic [ATTR_W-1:0] cfg_attribute_i,
  input  wire logic              res_ready_i,
  output logic                   res_valid_o,
  output ttcw_result_t           res_o
);

  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     top_q, top_d;
  logic [ADDR_W-1:0]    cnt_q, cnt_d;
  logic [TAB_CNT_W-1:0] tab_q, tab_d;
  logic [ATTR_W-1:0]    attr_q, attr_d;
  logic [ROW_W-1:0]     blank_row_q, blank_row_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [CHAR_W-1:0]    ch_q, ch_d;
  logic [RROW_W-1:0]    rr_q, rr_d;
  logic [RCOL_W-1:0]    rc_q, rc_d;
  logic [CELL_W-1:0]    cell_q, cell_d;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [CELL_W-1:0]    mem_wdata;
  logic [CELL_W-1:0]    mem_rdata;

  logic [ROW_W-1:0]     top_next;
  logic                 last_row;
  logic [ROW_W-1:0]     bs_row;
  logic [COL_W-1:0]     bs_col;
  logic                 read_in_range;

  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] base,
                                                  input logic [COL_W-1:0] c);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, base};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLS)) + ADDR_W'(c);
  endfunction

  assign top_next = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
  assign last_row = (row_q == ROW_W'(ROWS - 1));
  assign read_in_range = (int'(rr_q) < ROWS) && (int'(rc_q) < COLS);

  always_comb begin
    bs_row = row_q;
    bs_col = col_q;
    if (col_q != '0) begin
      bs_col = col_q - COL_W'(1);
    end else if (row_q != '0) begin
      bs_col = COL_W'(COLS - 1);
      bs_row = row_q - ROW_W'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    tab_d       = tab_q;
    blank_row_d = blank_row_q;
    mode_d      = mode_q;
    ch_d        = ch_q;
    rr_d        = rr_q;
    rc_d        = rc_q;
    cell_d      = cell_q;
    attr_d      = cfg_valid_i ? cfg_attribute_i : attr_q;
    mem_we      = 1'b0;
    mem_addr    = phys_addr(row_q, top_q, col_q);
    mem_wdata   = {attr_q, CH_BLANK};

    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = cnt_q;
        mem_wdata = CELL_RESET;
        cnt_d     = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          ch_d    = char_code_i;
          rr_d    = read_row_i;
          rc_d    = read_col_i;
          tab_d   = '0;
          cell_d  = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mode_q)
          MODE_PUT: begin
            priority if (ch_q == CH_NEWLINE) begin
              col_d = '0;
              if (last_row) begin
                blank_row_d = top_q;
                top_d       = top_next;
                cnt_d       = '0;
                state_d     = S_BLANK;
              end else begin
                row_d   = row_q + ROW_W'(1);
                state_d = S_DONE;
              end
            end else if (ch_q == CH_BACKSPACE) begin
              row_d    = bs_row;
              col_d    = bs_col;
              mem_we   = 1'b1;
              mem_addr = phys_addr(bs_row, top_q, bs_col);
              state_d  = S_DONE;
            end else if (ch_q == CH_TAB) begin
              ch_d    = CH_SPACE;
              tab_d   = TAB_EXTRA;
              state_d = S_PUT;
            end else begin
              state_d = S_PUT;
            end
          end
          MODE_READ: begin
            if (read_in_range) begin
              mem_addr = phys_addr(ROW_W'(rr_q), top_q, COL_W'(rc_q));
              state_d  = S_READ;
            end else begin
              state_d = S_DONE;
            end
          end
          MODE_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            top_d   = '0;
            cnt_d   = '0;
            state_d = S_CLEAR;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = {attr_q, ch_q};
        if (col_q == COL_W'(COLS - 1)) begin
          col_d = '0;
          if (last_row) begin
            blank_row_d = top_q;
            top_d       = top_next;
            cnt_d       = '0;
            state_d     = S_BLANK;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
        if (state_d != S_BLANK) begin
          if (tab_q != '0) begin
            tab_d = tab_q - TAB_CNT_W'(1);
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_BLANK: begin
        mem_we   = 1'b1;
        mem_addr = phys_addr(blank_row_q, '0, COL_W'(cnt_q));
        cnt_d    = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(COLS - 1)) begin
          cnt_d = '0;
          if (tab_q != '0) begin
            tab_d   = tab_q - TAB_CNT_W'(1);
            state_d = S_PUT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = cnt_q;
        cnt_d    = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cell_d  = mem_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      cnt_q   <= '0;
      tab_q   <= '0;
      attr_q  <= ATTR_RESET;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      tab_q   <= tab_d;
      attr_q  <= attr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blank_row_q <= blank_row_d;
    mode_q      <= mode_d;
    ch_q        <= ch_d;
    rr_q        <= rr_d;
    rc_q        <= rc_d;
    cell_q      <= cell_d;
  end

  ttcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o.cell_value      = cell_q;
    res_o.cursor_row      = ROW_OUT_W'(row_q);
    res_o.cursor_col      = COL_OUT_W'(col_q);
    res_o.cursor_position = POS_W'(ADDR_W'(ADDR_W'(row_q) * ADDR_W'(COLS)) + ADDR_W'(col_q));
  end

endmodule

`default_nettype wire

[design/text_terminal_cell_writer.sv]
// ----------------------------------------------------------------------------
// text_terminal_cell_writer: character-cell text terminal
// Screen of ROWS x COLS attribute/character cells with a cursor, fed by
// put, read and clear items, with one registered result per item.
// ----------------------------------------------------------------------------
// All screen cells live in one single-port RAM, so cell writes and reads take
// turns on that port. A newline without scrolling writes no cell, a plain
// character writes one, a backspace blanks the cell at its new cursor, a tab
// writes four spaces, a read of a cell inside the screen reads one, and an
// out-of-range read or an unused mode touches none; each scroll also blanks
// the new bottom row of COLS cells (scrolling itself only moves a top-row
// pointer). A clear blanks all ROWS*COLS cells. After reset the RAM is swept
// to its reset contents, ROWS*COLS cells (2000 at the default size), during
// which no item is accepted; attribute writes are taken at any time.
`default_nettype none

module text_terminal_cell_writer
  import ttcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [MODE_W-1:0]    mode_i,
  input  wire logic [CHAR_W-1:0]    char_code_i,
  input  wire logic [RROW_W-1:0]    read_row_i,
  input  wire logic [RCOL_W-1:0]    read_col_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [CELL_W-1:0]         cell_value_o,
  output logic [ROW_OUT_W-1:0]      cursor_row_o,
  output logic [COL_OUT_W-1:0]      cursor_col_o,
  output logic [POS_W-1:0]          cursor_position_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [ATTR_W-1:0]    cfg_attribute_i
);

  logic         res_valid;
  logic         res_ready;
  ttcw_result_t res;
  ttcw_result_t out_q;
  logic         out_valid_q, out_valid_d;

  ttcw_engine #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .char_code_i    (char_code_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_attribute_i(cfg_attribute_i),
    .res_ready_i    (res_ready),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  assign cfg_ready_o = 1'b1;
  assign res_ready   = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_value_o      = out_q.cell_value;
  assign cursor_row_o      = out_q.cursor_row;
  assign cursor_col_o      = out_q.cursor_col;
  assign cursor_position_o = out_q.cursor_position;

  a_busy_while_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_stall_o)
    else $error("Engine holds a result while accepting items.");

  a_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ROWS <= 32) |-> (int'(cursor_row_o) < ROWS))
    else $error("Cursor row out of range.");

  a_col_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && COLS <= 128) |-> (int'(cursor_col_o) < COLS))
    else $error("Cursor column out of range.");

endmodule

`default_nettype wire

[sim/tb_text_terminal_cell_writer.sv]
// ----------------------------------------------------------------------------
// tb_text_terminal_cell_writer: self-checking bench for the text terminal
// A directed script of reads, puts, control characters, a clear and a full
// scroll precedes six phases of random items, each with its own attribute.
// Every result is compared field by field with a value typed in the script
// or a bench model of screen and cursor; both sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_text_terminal_cell_writer;
  import ttcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int SCREEN_CELLS = COLS * ROWS;
  localparam int TAB_WIDTH = 4;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 50;
  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] ch;
    logic [RROW_W-1:0] rr;
    logic [RCOL_W-1:0] rc;
  } term_item_t;

  typedef struct {
    term_item_t   item;
    int           reps;
    bit           typed;
    ttcw_result_t want;
  } script_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [MODE_W-1:0]    mode_i = MODE_PUT;
  logic [CHAR_W-1:0]    char_code_i = '0;
  logic [RROW_W-1:0]    read_row_i = '0;
  logic [RCOL_W-1:0]    read_col_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CELL_W-1:0]    cell_value_o;
  logic [ROW_OUT_W-1:0] cursor_row_o;
  logic [COL_OUT_W-1:0] cursor_col_o;
  logic [POS_W-1:0]     cursor_position_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [ATTR_W-1:0]    cfg_attribute_i = '0;

  text_terminal_cell_writer #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .char_code_i       (char_code_i),
    .read_row_i        (read_row_i),
    .read_col_i        (read_col_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cell_value_o      (cell_value_o),
    .cursor_row_o      (cursor_row_o),
    .cursor_col_o      (cursor_col_o),
    .cursor_position_o (cursor_position_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_attribute_i   (cfg_attribute_i)
  );

  logic [CELL_W-1:0] screen_img [SCREEN_CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [ATTR_W-1:0] attr_now;

  ttcw_result_t pending_results [$];
  ttcw_result_t oldest;
  int           fail_count = 0;
  int           burst_left = 0;
  longint       cycle_count = 0;
  bit           hold_off_req = 1'b0;

  script_row_t script [27] = '{
    '{'{MODE_READ, 8'h00, 5'd0, 7'd0}, 1, 1, '{16'h0F00, 5'd0, 7'd0, 11'd0}},
    '{'{MODE_READ, 8'h00, 5'd24, 7'd79}, 1, 1, '{16'h0F00, 5'd0, 7'd0, 11'd0}},
    '{'{MODE_READ, 8'h00, 5'd25, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd0, 11'd0}},
    '{'{MODE_READ, 8'hFF, 5'd31, 7'd127}, 1, 1, '{16'h0000, 5'd0, 7'd0, 11'd0}},
    '{'{MODE_READ, 8'h00, 5'd0, 7'd80}, 1, 1, '{16'h0000, 5'd0, 7'd0, 11'd0}},
    '{'{MODE_UNUSED, 8'hFF, 5'd31, 7'd127}, 1, 1, '{16'h0000, 5'd0, 7'd0, 11'd0}},
    '{'{MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd0, 11'd0}},
    '{'{MODE_PUT, 8'h41, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd1, 11'd1}},
    '{'{MODE_READ, 8'h00, 5'd0, 7'd0}, 1, 1, '{16'h0F41, 5'd0, 7'd1, 11'd1}},
    '{'{MODE_PUT, 8'h00, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd2, 11'd2}},
    '{'{MODE_PUT, 8'hFF, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd3, 11'd3}},
    '{'{MODE_PUT, CH_TAB, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd7, 11'd7}},
    '{'{MODE_READ, 8'h00, 5'd0, 7'd6}, 1, 1, '{16'h0F20, 5'd0, 7'd7, 11'd7}},
    '{'{MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd6, 11'd6}},
    '{'{MODE_READ, 8'h00, 5'd0, 7'd6}, 1, 1, '{16'h0F00, 5'd0, 7'd6, 11'd6}},
    '{'{MODE_PUT, CH_NEWLINE, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd1, 7'd0, 11'd80}},
    '{'{MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd79, 11'd79}},
    '{'{MODE_PUT, 8'h5A, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd1, 7'd0, 11'd80}},
    '{'{MODE_READ, 8'h00, 5'd0, 7'd79}, 1, 1, '{16'h0F5A, 5'd1, 7'd0, 11'd80}},
    '{'{MODE_CLEAR, 8'h00, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd0, 7'd0, 11'd0}},
    '{'{MODE_PUT, CH_NEWLINE, 5'd0, 7'd0}, 24, 1, '{16'h0000, 5'd24, 7'd0, 11'd1920}},
    '{'{MODE_PUT, 8'h42, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd24, 7'd1, 11'd1921}},
    '{'{MODE_PUT, CH_NEWLINE, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd24, 7'd0, 11'd1920}},
    '{'{MODE_READ, 8'h00, 5'd23, 7'd0}, 1, 1, '{16'h0F42, 5'd24, 7'd0, 11'd1920}},
    '{'{MODE_PUT, CH_BACKSPACE, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd23, 7'd79, 11'd1919}},
    '{'{MODE_PUT, CH_NEWLINE, 5'd0, 7'd0}, 1, 1, '{16'h0000, 5'd24, 7'd0, 11'd1920}},
    '{'{MODE_PUT, CH_TAB, 5'd0, 7'd0}, 20, 0, '{16'h0000, 5'd0, 7'd0, 11'd0}}
  };

  function automatic void screen_reset();
    foreach (screen_img[i]) screen_img[i] = CELL_RESET;
    cur_row = 0;
    cur_col = 0;
    attr_now = ATTR_RESET;
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    if (cur_row >= ROWS - 1) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_img[i] = screen_img[i + COLS];
      for (int i = (ROWS - 1) * COLS; i < SCREEN_CELLS; i++) screen_img[i] = {attr_now, CH_BLANK};
    end else begin
      cur_row++;
    end
  endfunction

  function automatic void put_glyph(input logic [CHAR_W-1:0] ch);
    screen_img[cur_row * COLS + cur_col] = {attr_now, ch};
    cur_col++;
    if (cur_col >= COLS) line_feed();
  endfunction

  function automatic ttcw_result_t terminal_step(input term_item_t it);
    ttcw_result_t r;
    int unsigned  pos;
    r = '0;
    case (it.mode)
      MODE_PUT: begin
        if (it.ch == CH_NEWLINE) begin
          line_feed();
        end else if (it.ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_col = COLS - 1;
            cur_row--;
          end
          screen_img[cur_row * COLS + cur_col] = {attr_now, CH_BLANK};
        end else if (it.ch == CH_TAB) begin
          repeat (TAB_WIDTH) put_glyph(CH_SPACE);
        end else begin
          put_glyph(it.ch);
        end
      end
      MODE_READ: begin
        if (it.rr < ROWS && it.rc < COLS) r.cell_value = screen_img[it.rr * COLS + it.rc];
      end
      MODE_CLEAR: begin
        foreach (screen_img[i]) screen_img[i] = {attr_now, CH_BLANK};
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
      end
    endcase
    pos = cur_row * COLS + cur_col;
    r.cursor_row = ROW_OUT_W'(cur_row);
    r.cursor_col = COL_OUT_W'(cur_col);
    r.cursor_position = POS_W'(pos);
    return r;
  endfunction

  function automatic term_item_t draw_item();
    term_item_t it;
    int         sel;
    int         sub;
    it.ch = CHAR_W'($urandom);
    it.rr = RROW_W'($urandom);
    it.rc = RCOL_W'($urandom);
    sel = $urandom_range(0, 999);
    sub = $urandom_range(0, 99);
    if (sel < 660) begin
      it.mode = MODE_PUT;
      if (sub < 20) it.ch = CH_NEWLINE;
      else if (sub < 28) it.ch = CH_BACKSPACE;
      else if (sub < 36) it.ch = CH_TAB;
      else if (sub < 80) it.ch = CHAR_W'($urandom_range(32, 126));
    end else if (sel < 977) begin
      it.mode = MODE_READ;
      if (sub >= 10) begin
        it.rr = (sub < 55) ? RROW_W'(cur_row) : RROW_W'($urandom_range(0, ROWS - 1));
        it.rc = RCOL_W'($urandom_range(0, COLS - 1));
      end
    end else if (sel < 997) begin
      it.mode = MODE_UNUSED;
    end else begin
      it.mode = MODE_CLEAR;
    end
    return it;
  endfunction

  task automatic offer_item(input term_item_t it, output ttcw_result_t predicted);
    in_valid_i <= 1'b1;
    mode_i <= it.mode;
    char_code_i <= it.ch;
    read_row_i <= it.rr;
    read_col_i <= it.rc;
    do @(posedge clk_i); while (in_stall_o);
    predicted = terminal_step(it);
  endtask

  task automatic pace_sender(input bit drain);
    int gap;
    if (drain || burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (drain && pending_results.size() != 0) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_attribute_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    attr_now = value;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_terminal_cell_writer verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: cell=%h row=%0d col=%0d pos=%0d",
                   cell_value_o, cursor_row_o, cursor_col_o, cursor_position_o);
      end else begin
        oldest = pending_results.pop_front();
        if (cell_value_o !== oldest.cell_value || cursor_row_o !== oldest.cursor_row ||
            cursor_col_o !== oldest.cursor_col ||
            cursor_position_o !== oldest.cursor_position) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: want cell=%h row=%0d col=%0d pos=%0d, got cell=%h row=%0d col=%0d pos=%0d",
                     oldest.cell_value, oldest.cursor_row, oldest.cursor_col,
                     oldest.cursor_position, cell_value_o, cursor_row_o, cursor_col_o,
                     cursor_position_o);
        end
      end
    end
  end

  // The receiver mixes free-flowing runs, heavy and light stalling, and one
  // long hold-off so that the block backs up and stalls its input.
  initial begin
    bit hold_taken;
    int run;
    hold_taken = 1'b0;
    forever begin
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        run = $urandom_range(1, 40);
        case ($urandom_range(0, 2))
          0: begin
            out_stall_i <= 1'b0;
            repeat (run) @(posedge clk_i);
          end
          1: begin
            repeat (run) begin
              out_stall_i <= 1'($urandom_range(0, 1));
              @(posedge clk_i);
            end
          end
          default: begin
            repeat (run) begin
              out_stall_i <= ($urandom_range(0, 7) == 0);
              @(posedge clk_i);
            end
          end
        endcase
      end
    end
  end

  initial begin
    ttcw_result_t predicted;
    term_item_t   it;
    screen_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        offer_item(script[r].item, predicted);
        if (script[r].typed && k == script[r].reps - 1) pending_results.push_back(script[r].want);
        else pending_results.push_back(predicted);
        pace_sender(1'b0);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      pace_sender(1'b1);
      case (p)
        0: write_attribute(8'h00);
        1: write_attribute(8'hFF);
        2: write_attribute(8'h70);
        default: write_attribute(ATTR_W'($urandom));
      endcase
      if (p == 1) hold_off_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it = draw_item();
        offer_item(it, predicted);
        pending_results.push_back(predicted);
        pace_sender(p == 3 && n == ITEMS_PER_PHASE / 2);
      end
    end

    pace_sender(1'b1);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("text_terminal_cell_writer verification clean");
    end else begin
      $display("text_terminal_cell_writer verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/ttcw_pkg.sv
design/ttcw_ram.sv
design/ttcw_engine.sv
design/text_terminal_cell_writer.sv
sim/tb_text_terminal_cell_writer.sv
